>>> src/wbps_pkg.sv
// Package for the wildcard byte pattern scanner: sizes, register codes,
// lane and pattern types, pattern byte lookup. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

    localparam int PATTERN_BYTES = 32;
    localparam int POSITION_BITS = 48;
    localparam int IDX_W         = ($clog2(PATTERN_BYTES) > 5) ? $clog2(PATTERN_BYTES) : 5;
    localparam int PLEN_W        = 6;
    localparam int RANGE_W       = 48;
    localparam int ADDR_W        = 64;
    localparam int OFFSET_W      = 32;
    localparam int PADDR_W       = 6;
    localparam int PDATA_W       = 64;

    localparam logic [7:0] WILD_STAR  = 8'h2A;
    localparam logic [7:0] WILD_QUERY = 8'h3F;

    typedef enum logic [2:0] {
        REG_PAT_A,
        REG_PAT_B,
        REG_PAT_C,
        REG_PAT_D,
        REG_PAT_LEN,
        REG_BASE,
        REG_RANGE,
        REG_OFFSET
    } t_reg_idx;

    typedef logic [3:0][7:0][7:0] t_pat_words;

    typedef struct packed {
        logic [7:0] data;
        logic       ok;
    } t_lane;

    typedef struct packed {
        logic       active;
        logic       wild;
        logic [7:0] data;
    } t_pat;

    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     last;
        logic [POSITION_BITS-1:0] pos;
    } t_tok;

    typedef struct packed {
        logic                     valid;
        logic                     found;
        logic [POSITION_BITS-1:0] start;
    } t_res;

    function automatic logic [7:0] pattern_byte(input t_pat_words words,
                                                input logic [IDX_W-1:0] k);
        logic [7:0] b;
        b = '0;
        if ({1'b0, k} < (IDX_W + 1)'(32)) begin
            b = words[k[4:3]][k[2:0]];
        end
        return b;
    endfunction

endpackage

`default_nettype wire

>>> src/wbps_if.sv
// Valid/ready channel interfaces for scanner input beats and result beats.
// Depends on wbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wbps_in_if import wbps_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       readable;
    logic       scan_first;
    logic       scan_last;

    modport source (output valid, data_byte, readable, scan_first, scan_last, input ready);
    modport sink   (input valid, data_byte, readable, scan_first, scan_last, output ready);
endinterface

interface wbps_out_if import wbps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [ADDR_W-1:0] match_address;

    modport source (output valid, found, match_address, input ready);
    modport sink   (input valid, found, match_address, output ready);
endinterface

`default_nettype wire

>>> src/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner: cell chain, decision and
// result stages. Depends on wbps_pkg, wbps_if, wbps_cfg and wbps_cell.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  i_in     | in  | valid/ready   | data_byte, readable, scan_first, scan_last
//  o_res    | out | valid/ready   | found, match_address
//  apb      | in  | psel/penable  | paddr, pwdata, prdata (pready tied high)
//
// One byte beat per cycle; a result for the beat that completes the window
// reaches o_res through the cell lane, compare, decide and address registers.
// Synchronous active-low reset empties the cell chain and the scan state.
// A stalled o_res holds its beat while the chain keeps advancing; only when a
// second result waits in the decide register does every stage hold and
// i_in.ready drop.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_scanner import wbps_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    wbps_in_if.sink                  i_in,
    wbps_out_if.source               o_res,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready
);

    t_pat                      w_align [PATTERN_BYTES];
    logic [IDX_W-1:0]          w_len_m1;
    logic [ADDR_W-1:0]         w_base;
    logic [RANGE_W-1:0]        w_range;
    logic [OFFSET_W-1:0]       w_offset;
    t_lane                     w_lane  [PATTERN_BYTES];
    logic [PATTERN_BYTES-1:0]  w_match;
    t_lane                     w_new;
    logic                      w_en;
    logic                      w_out_ld;
    logic                      w_acc;
    logic [POSITION_BITS-1:0]  w_pos;

    logic [POSITION_BITS-1:0]  r_pos;
    t_tok                      r_s1;
    t_tok                      r_s2;
    logic                      r_done;
    logic                      n_done;
    t_res                      r_res;
    t_res                      n_res;
    logic                      r_out_valid;
    logic                      r_out_found;
    logic [ADDR_W-1:0]         r_out_addr;
    logic [ADDR_W-1:0]         n_out_addr;

    wbps_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_align  (w_align),
        .o_len_m1 (w_len_m1),
        .o_base   (w_base),
        .o_range  (w_range),
        .o_offset (w_offset)
    );

    assign w_out_ld   = ~r_out_valid | o_res.ready;
    assign w_en       = w_out_ld | ~r_res.valid;
    assign w_acc      = w_en & i_in.valid;
    assign i_in.ready = w_en;
    assign w_new.data = i_in.data_byte;
    assign w_new.ok   = i_in.readable;
    assign w_pos      = i_in.scan_first ? '0 : r_pos;

    for (genvar h = 0; h < PATTERN_BYTES; h++) begin : g_cell
        wbps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_shift (w_acc),
            .i_clear ((h != 0) && i_in.scan_first),
            .i_lane  ((h == 0) ? w_new : w_lane[(h == 0) ? 0 : h - 1]),
            .i_pat   (w_align[h]),
            .o_lane  (w_lane[h]),
            .o_match (w_match[h])
        );
    end

    // Shift stage tags and the compare stage tags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_s1  <= '0;
            r_s2  <= '0;
        end else if (w_en) begin
            r_s1.valid <= i_in.valid;
            r_s1.first <= i_in.scan_first;
            r_s1.last  <= i_in.scan_last;
            r_s1.pos   <= w_pos;
            r_s2       <= r_s1;
            if (i_in.valid) begin
                r_pos <= w_pos + POSITION_BITS'(1);
            end
        end
    end

    // Decide: window complete, start in range, scan still open.
    always_comb begin
        logic                     eff_done;
        logic [POSITION_BITS-1:0] start;
        logic                     in_range;
        logic                     hit;
        eff_done    = r_s2.first ? 1'b0 : r_done;
        start       = r_s2.pos - POSITION_BITS'(w_len_m1);
        in_range    = (r_s2.pos >= POSITION_BITS'(w_len_m1))
                    && (64'(start) <= 64'(w_range));
        hit         = (&w_match) & in_range;
        n_res.valid = r_s2.valid & ~eff_done & (hit | r_s2.last);
        n_res.found = hit;
        n_res.start = start;
        n_done      = r_s2.valid ? (eff_done | hit | r_s2.last) : r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_res  <= '0;
        end else if (w_en) begin
            r_done <= n_done;
            r_res  <= n_res;
        end
    end

    // Address: base plus start, offset folded into the low word.
    always_comb begin
        logic [ADDR_W-1:0]   start64;
        logic [ADDR_W-1:0]   sum;
        logic [31:0]         lo;
        start64 = 64'(r_res.start);
        sum     = w_base + start64;
        lo      = w_base[31:0] + start64[31:0] + w_offset;
        n_out_addr = r_res.found ? {sum[63:32], lo} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ld) begin
            r_out_valid <= r_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            r_out_found <= r_res.found;
            r_out_addr  <= n_out_addr;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.found         = r_out_found;
    assign o_res.match_address = r_out_addr;

endmodule

`default_nettype wire

>>> src/wbps_cfg.sv
// APB register file for the scanner plus the per-cell aligned pattern.
// Depends on wbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wbps_cfg import wbps_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready,
    output t_pat                      o_align [PATTERN_BYTES],
    output logic      [IDX_W-1:0]     o_len_m1,
    output logic      [ADDR_W-1:0]    o_base,
    output logic      [RANGE_W-1:0]   o_range,
    output logic      [OFFSET_W-1:0]  o_offset
);

    t_pat_words           r_words;
    logic [PLEN_W-1:0]    r_plen;
    logic [ADDR_W-1:0]    r_base;
    logic [RANGE_W-1:0]   r_range;
    logic [OFFSET_W-1:0]  r_offset;
    t_pat                 r_align [PATTERN_BYTES];
    t_pat                 n_align [PATTERN_BYTES];
    logic [IDX_W-1:0]     r_len_m1;
    logic [IDX_W-1:0]     n_len_m1;
    t_reg_idx             w_idx;
    logic                 w_wr;

    assign w_idx  = t_reg_idx'(paddr[5:3]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words  <= '0;
            r_plen   <= PLEN_W'(1);
            r_base   <= '0;
            r_range  <= '0;
            r_offset <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_PAT_A:   r_words[0] <= pwdata;
                REG_PAT_B:   r_words[1] <= pwdata;
                REG_PAT_C:   r_words[2] <= pwdata;
                REG_PAT_D:   r_words[3] <= pwdata;
                REG_PAT_LEN: r_plen     <= pwdata[PLEN_W-1:0];
                REG_BASE:    r_base     <= pwdata;
                REG_RANGE:   r_range    <= pwdata[RANGE_W-1:0];
                REG_OFFSET:  r_offset   <= pwdata[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PAT_A:   prdata = r_words[0];
            REG_PAT_B:   prdata = r_words[1];
            REG_PAT_C:   prdata = r_words[2];
            REG_PAT_D:   prdata = r_words[3];
            REG_PAT_LEN: prdata = PDATA_W'(r_plen);
            REG_BASE:    prdata = r_base;
            REG_RANGE:   prdata = PDATA_W'(r_range);
            REG_OFFSET:  prdata = PDATA_W'(r_offset);
            default:     prdata = '0;
        endcase
    end

    // Clamp the length; an empty pattern is a single readable-only cell.
    always_comb begin
        if (r_plen == '0) begin
            n_len_m1 = '0;
        end else if ({1'b0, r_plen} > (PLEN_W + 1)'(PATTERN_BYTES)) begin
            n_len_m1 = IDX_W'(PATTERN_BYTES - 1);
        end else begin
            n_len_m1 = IDX_W'(r_plen - PLEN_W'(1));
        end
    end

    // Cell h faces pattern byte len-1-h.
    always_comb begin
        logic [7:0]       pb;
        logic [IDX_W-1:0] k;
        for (int h = 0; h < PATTERN_BYTES; h++) begin
            k  = n_len_m1 - IDX_W'(h);
            pb = pattern_byte(r_words, k);
            n_align[h].active = IDX_W'(h) <= n_len_m1;
            n_align[h].wild   = (r_plen == '0) | (pb == WILD_STAR) | (pb == WILD_QUERY);
            n_align[h].data   = pb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_align  <= n_align;
        r_len_m1 <= n_len_m1;
    end

    assign o_align  = r_align;
    assign o_len_m1 = r_len_m1;
    assign o_base   = r_base;
    assign o_range  = r_range;
    assign o_offset = r_offset;

endmodule

`default_nettype wire

>>> src/wbps_cell.sv
// One window cell: holds a byte and its readable flag, passes it on to the
// next cell each beat and registers its compare against the aligned pattern.
// Depends on wbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wbps_cell import wbps_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_shift,
    input  wire logic  i_clear,
    input  wire t_lane i_lane,
    input  wire t_pat  i_pat,
    output t_lane      o_lane,
    output logic       o_match
);

    t_lane r_lane;
    logic  r_match;
    logic  n_match;

    assign n_match = ~i_pat.active
                   | (r_lane.ok & (i_pat.wild | (r_lane.data == i_pat.data)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane  <= '0;
            r_match <= 1'b0;
        end else begin
            if (i_shift) begin
                r_lane <= i_clear ? '0 : i_lane;
            end
            if (i_en) begin
                r_match <= n_match;
            end
        end
    end

    assign o_lane  = r_lane;
    assign o_match = r_match;

endmodule

`default_nettype wire

>>> dv/wildcard_byte_pattern_scanner_tb.sv
// Testbench for wildcard_byte_pattern_scanner: directed and random byte scans with
// random idling on both channels, checked against an in-bench match predictor.
// Depends on wbps_pkg, wbps_if and the scanner RTL.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_tb;
    import wbps_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 10;
    localparam int PHASE_BYTES = 93;
    localparam int DRAIN_WAIT  = 8;

    typedef struct {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } t_match_report;

    class t_match_tracker;
        logic [63:0]              pat_word[4];
        logic [PLEN_W-1:0]        pat_len;
        logic [ADDR_W-1:0]        base;
        logic [RANGE_W-1:0]       last_start;
        logic [OFFSET_W-1:0]      offset;
        logic [7:0]               hist_byte[PATTERN_BYTES];
        bit                       hist_ok[PATTERN_BYTES];
        logic [POSITION_BITS-1:0] position;
        bit                       finished;
        t_match_report            pending_reports[$];
        int                       errors;
        int                       reports_seen;
        int                       bytes_taken;

        function new();
            foreach (pat_word[i]) pat_word[i] = '0;
            pat_len = PLEN_W'(1);
            base = '0;
            last_start = '0;
            offset = '0;
            restart();
        endfunction

        function void restart();
            foreach (hist_byte[i]) begin
                hist_byte[i] = '0;
                hist_ok[i] = 1'b0;
            end
            position = '0;
            finished = 1'b0;
        endfunction

        function logic [7:0] pattern_at(int k);
            return pat_word[k / 8][(k % 8) * 8 +: 8];
        endfunction

        function int window_len();
            if (pat_len == 0) return 1;
            if (pat_len > PATTERN_BYTES) return PATTERN_BYTES;
            return int'(pat_len);
        endfunction

        function void set_reg(t_reg_idx idx, logic [63:0] v);
            case (idx)
                REG_PAT_A:   pat_word[0] = v;
                REG_PAT_B:   pat_word[1] = v;
                REG_PAT_C:   pat_word[2] = v;
                REG_PAT_D:   pat_word[3] = v;
                REG_PAT_LEN: pat_len = v[PLEN_W-1:0];
                REG_BASE:    base = v;
                REG_RANGE:   last_start = v[RANGE_W-1:0];
                REG_OFFSET:  offset = v[OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        function bit window_hit(int len);
            logic [7:0] pb;
            for (int k = 0; k < len; k++) begin
                if (!hist_ok[len - 1 - k]) return 1'b0;
                if (pat_len == 0) continue;
                pb = pattern_at(k);
                if (pb == WILD_STAR || pb == WILD_QUERY) continue;
                if (hist_byte[len - 1 - k] != pb) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void take_byte(logic [7:0] data, logic ok, logic first, logic last);
            int                       len;
            logic [POSITION_BITS-1:0] p;
            logic [POSITION_BITS-1:0] start;
            logic [ADDR_W-1:0]        a;
            logic [31:0]              lo;
            bytes_taken++;
            if (first) restart();
            if (finished) return;
            for (int i = PATTERN_BYTES - 1; i > 0; i--) begin
                hist_byte[i] = hist_byte[i - 1];
                hist_ok[i] = hist_ok[i - 1];
            end
            hist_byte[0] = data;
            hist_ok[0] = ok;
            p = position;
            position = position + 1'b1;
            len = window_len();
            if (p >= POSITION_BITS'(len - 1)) begin
                start = p - POSITION_BITS'(len - 1);
                if (start <= last_start && window_hit(len)) begin
                    a = base + ADDR_W'(start);
                    lo = a[31:0] + offset;
                    pending_reports.push_back('{1'b1, {a[63:32], lo}});
                    finished = 1'b1;
                    return;
                end
            end
            if (last) begin
                pending_reports.push_back('{1'b0, '0});
                finished = 1'b1;
            end
        endfunction

        function void note_failure(string msg);
            errors++;
            if (errors <= 10) $display("%t: %s", $realtime, msg);
        endfunction

        function void check_report(logic found, logic [ADDR_W-1:0] addr);
            t_match_report exp_r;
            reports_seen++;
            if (pending_reports.size() == 0) begin
                note_failure($sformatf("unexpected result beat found=%0b addr=%h", found, addr));
                return;
            end
            exp_r = pending_reports.pop_front();
            if (found !== exp_r.found)
                note_failure($sformatf("found mismatch: exp %0b got %0b", exp_r.found, found));
            if (addr !== exp_r.addr)
                note_failure($sformatf("match_address mismatch: exp %h got %h", exp_r.addr, addr));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    bit in_quiet;
    bit out_quiet;
    int idle_cycles;
    t_match_tracker sb = new();

    wbps_in_if  in_bus();
    wbps_out_if res_bus();

    wildcard_byte_pattern_scanner u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (res_bus.valid && res_bus.ready)
                sb.check_report(res_bus.found, res_bus.match_address);
            if (in_bus.valid && in_bus.ready)
                sb.take_byte(in_bus.data_byte, in_bus.readable, in_bus.scan_first,
                             in_bus.scan_last);
        end
        if ((in_bus.valid && in_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int stall;
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0) out_quiet = !out_quiet;
            stall = out_quiet ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!res_bus.valid);
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic ok, input logic first,
                             input logic last);
        int gap;
        if ($urandom_range(0, 15) == 0) in_quiet = !in_quiet;
        gap = in_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.data_byte <= d;
        in_bus.readable <= ok;
        in_bus.scan_first <= first;
        in_bus.scan_last <= last;
        do @(posedge i_clk); while (!in_bus.ready);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain every expected report, then hold for the pipeline to empty.
    task automatic settle();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic setup_phase(input int ph);
        logic [63:0]        w[4];
        logic [7:0]         b;
        logic [PLEN_W-1:0]  plen;
        logic [ADDR_W-1:0]  base_v;
        logic [RANGE_W-1:0] rng;
        logic [31:0]        ofs;
        for (int k = 0; k < 32; k++) begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 4) == 0) b = $urandom_range(0, 1) ? WILD_STAR : WILD_QUERY;
            w[k / 8][(k % 8) * 8 +: 8] = b;
        end
        if (ph == 1) foreach (w[i]) w[i] = '1;
        if (ph == 3) foreach (w[i]) w[i] = '0;
        case (ph)
            0: plen = PLEN_W'(0);
            1: plen = PLEN_W'(32);
            2: plen = PLEN_W'(45);
            3: plen = PLEN_W'(63);
            4: plen = PLEN_W'(1);
            default: plen = $urandom_range(0, 2) == 0 ? PLEN_W'($urandom_range(1, 32))
                                                      : PLEN_W'($urandom_range(1, 8));
        endcase
        base_v = {$urandom, $urandom};
        if (ph == 1) base_v = '1;
        if (ph == 2) base_v = '0;
        if (ph == 4) base_v = 64'h0000_0001_FFFF_FFF0;
        rng = $urandom_range(0, 1) ? RANGE_W'($urandom_range(0, 30))
                                   : RANGE_W'({$urandom, $urandom});
        if (ph == 0) rng = RANGE_W'(3);
        if (ph == 1) rng = '1;
        if (ph == 2) rng = '0;
        ofs = $urandom;
        if (ph == 1) ofs = '1;
        if (ph == 2) ofs = '0;
        write_reg(REG_PAT_A, w[0]);
        write_reg(REG_PAT_B, w[1]);
        write_reg(REG_PAT_C, w[2]);
        write_reg(REG_PAT_D, w[3]);
        write_reg(REG_PAT_LEN, 64'(plen));
        write_reg(REG_BASE, base_v);
        write_reg(REG_RANGE, 64'(rng));
        write_reg(REG_OFFSET, 64'(ofs));
    endtask

    // One scan: mostly well formed with a planted pattern, some without an end, some noise.
    task automatic gen_scan();
        logic [7:0] bytes_q[64];
        bit         ok_q[64];
        int         kind;
        int         len;
        int         span;
        int         n;
        int         s;
        int         j;
        bit         narrow;
        logic [7:0] pb;
        kind = $urandom_range(0, 19);
        len = sb.window_len();
        if (kind >= 18) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
                          $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
            return;
        end
        span = (sb.last_start < 24) ? int'(sb.last_start) : 24;
        n = $urandom_range(1, len + span + 4);
        if (n > 63) n = 63;
        narrow = $urandom_range(0, 1);
        for (int i = 0; i < n; i++) begin
            if (!narrow) bytes_q[i] = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 1)) bytes_q[i] = sb.pattern_at($urandom_range(0, len - 1));
            else case ($urandom_range(0, 3))
                0: bytes_q[i] = 8'h00;
                1: bytes_q[i] = 8'hFF;
                2: bytes_q[i] = WILD_STAR;
                default: bytes_q[i] = WILD_QUERY;
            endcase
            ok_q[i] = $urandom_range(0, 24) != 0;
        end
        if (n >= len && $urandom_range(0, 9) < 7) begin
            s = $urandom_range(0, (n - len < span + 2) ? n - len : span + 2);
            for (int k = 0; k < len; k++) begin
                pb = sb.pattern_at(k);
                bytes_q[s + k] = (sb.pat_len == 0 || pb == WILD_STAR || pb == WILD_QUERY)
                                 ? 8'($urandom_range(0, 255)) : pb;
                ok_q[s + k] = 1'b1;
            end
            if ($urandom_range(0, 4) == 0) begin
                j = s + $urandom_range(0, len - 1);
                if ($urandom_range(0, 1)) bytes_q[j] ^= 8'(1 << $urandom_range(0, 7));
                else ok_q[j] = 1'b0;
            end
        end
        for (int i = 0; i < n; i++)
            send_byte(bytes_q[i], ok_q[i], i == 0, kind < 15 && i == n - 1);
    endtask

    initial begin
        int start;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_bus.valid <= 1'b0;
        in_bus.data_byte <= '0;
        in_bus.readable <= 1'b0;
        in_bus.scan_first <= 1'b0;
        in_bus.scan_last <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: match without scan_first, ignored tail, one-byte scan, range exhausted
        send_byte(8'h00, 1'b1, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0, 1'b1);
        send_byte(8'h55, 1'b1, 1'b1, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0, 1'b1);
        settle();

        write_reg(REG_PAT_A, 64'hFFFF_FFFF_423F_2A41);
        write_reg(REG_PAT_B, '1);
        write_reg(REG_PAT_C, '1);
        write_reg(REG_PAT_D, '1);
        write_reg(REG_PAT_LEN, 64'd4);
        write_reg(REG_BASE, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(REG_RANGE, 64'd3);
        write_reg(REG_OFFSET, 64'hFFFF_FFFF);
        // wildcard match at start 1 with address wrap, then a short scan
        send_byte(8'h10, 1'b1, 1'b1, 1'b0);
        send_byte(8'h41, 1'b1, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0, 1'b0);
        send_byte(8'h42, 1'b1, 1'b0, 1'b0);
        send_byte(8'h77, 1'b1, 1'b0, 1'b1);
        send_byte(8'h41, 1'b1, 1'b1, 1'b0);
        send_byte(8'h2A, 1'b1, 1'b0, 1'b0);
        send_byte(8'h3F, 1'b1, 1'b0, 1'b1);
        // match completed by the last byte, then an unreadable byte under a wildcard
        send_byte(8'h41, 1'b1, 1'b1, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0, 1'b0);
        send_byte(8'h42, 1'b1, 1'b0, 1'b1);
        send_byte(8'h41, 1'b1, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0, 1'b0);
        send_byte(8'h42, 1'b1, 1'b0, 1'b1);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            setup_phase(ph);
            start = sb.bytes_taken;
            while (sb.bytes_taken - start < PHASE_BYTES
                   || (ph == PHASES - 1 && sb.reports_seen < 40))
                gen_scan();
            settle();
        end

        if (sb.errors + sb.pending_reports.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
src/wbps_pkg.sv
src/wbps_if.sv
src/wbps_cfg.sv
src/wbps_cell.sv
src/wildcard_byte_pattern_scanner.sv
dv/wildcard_byte_pattern_scanner_tb.sv
